// ===== hw/rtl/sun_tracker_servo_controller_macros.svh =====
// assertion macros for the sun tracker servo controller
// expects a clock named clock and an active-high reset named reset in scope
`ifndef SUN_TRACKER_SERVO_CONTROLLER_MACROS_SVH
`define SUN_TRACKER_SERVO_CONTROLLER_MACROS_SVH

// same-cycle implication, skipped while in reset
`define STTR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while in reset
`define STTR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sttr_pkg.sv =====
// shared types, constants and helpers for the sun tracker servo controller
// no dependencies
`default_nettype none

package sttr_pkg;

   // data widths
   localparam int SAMPLE_BITS = 12;
   localparam int PULSE_BITS  = 15;
   localparam int THR_BITS    = 11;
   localparam int STEP_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;
   // product width of the deviation test: threshold * (a + b)
   localparam int PROD_BITS   = SAMPLE_BITS + THR_BITS + 1;
   // scale on the difference side of the deviation test
   localparam int DIFF_SCALE  = 2000;

   // register reset values
   localparam logic [THR_BITS-1:0]   THR_RESET    = THR_BITS'(151);
   localparam logic [PULSE_BITS-1:0] LOW_RESET    = PULSE_BITS'(500);
   localparam logic [PULSE_BITS-1:0] CENTER_RESET = PULSE_BITS'(1500);
   localparam logic [PULSE_BITS-1:0] HIGH_RESET   = PULSE_BITS'(2500);
   localparam logic [STEP_BITS-1:0]  STEP_RESET   = STEP_BITS'(10);

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_PULSE_LOW = 3'd1,
      CSR_PULSE_CTR = 3'd2,
      CSR_PULSE_HIGH = 3'd3,
      CSR_RAMP_STEP = 3'd4
   } csr_idx_type;

   // axis target codes
   typedef enum logic [1:0] {
      POS_CENTER = 2'd0,
      POS_LOW    = 2'd1,
      POS_HIGH   = 2'd2
   } pos_type;

   // configuration seen by both axes
   typedef struct packed {
      logic [THR_BITS-1:0]   threshold;
      logic [PULSE_BITS-1:0] pulse_low;
      logic [PULSE_BITS-1:0] pulse_center;
      logic [PULSE_BITS-1:0] pulse_high;
      logic [STEP_BITS-1:0]  ramp_step;
   } cfg_type;

   // per-axis status toward the top level
   typedef struct packed {
      logic [PULSE_BITS-1:0] cur_pulse;
      logic [1:0]            cur_pos;
      logic [PULSE_BITS-1:0] nxt_pulse;
      logic [1:0]            nxt_pos;
      logic                  at_target;
   } axis_stat_type;

   // pulse width that belongs to a target code
   function automatic logic [PULSE_BITS-1:0] target_pulse(input logic [1:0] pos,
                                                          input cfg_type cfg);
      logic [PULSE_BITS-1:0] res;
      unique case (pos)
         POS_LOW:  res = cfg.pulse_low;
         POS_HIGH: res = cfg.pulse_high;
         default:  res = cfg.pulse_center;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sttr_axis.sv =====
// one servo axis: deviation test, target state and ramped pulse register
// depends on sttr_pkg
`default_nettype none

module sttr_axis
   import sttr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic                   cmd,
   input  wire logic [SAMPLE_BITS-1:0] low_side,
   input  wire logic [SAMPLE_BITS-1:0] high_side,
   input  wire cfg_type                cfg,
   output axis_stat_type               stat
);

   logic [PULSE_BITS-1:0]  pulse_ff, pulse_in;
   logic [1:0]             pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] diff;
   logic [SAMPLE_BITS:0]   sum;
   logic [PROD_BITS-1:0]   lhs, rhs;
   logic                   pass;
   logic [1:0]             decided;
   logic [PULSE_BITS-1:0]  tgt_cur, tgt_nxt, step_ext, gap, ramped;

   // deviation test: 2000*|a-b| > threshold*(a+b)
   always_comb begin
      diff = (low_side > high_side) ? (low_side - high_side) : (high_side - low_side);
      sum  = {1'b0, low_side} + {1'b0, high_side};
      lhs  = PROD_BITS'(diff) * PROD_BITS'(DIFF_SCALE);
      rhs  = PROD_BITS'(cfg.threshold) * PROD_BITS'(sum);
      pass = lhs > rhs;
      priority if (pass && low_side > high_side) begin
         decided = POS_LOW;
      end else if (pass && low_side < high_side) begin
         decided = POS_HIGH;
      end else begin
         decided = POS_CENTER;
      end
   end

   // one ramp step toward the current target, clamped at the target
   always_comb begin
      tgt_cur  = target_pulse(pos_ff, cfg);
      step_ext = PULSE_BITS'(cfg.ramp_step);
      priority if (pulse_ff < tgt_cur) begin
         gap    = tgt_cur - pulse_ff;
         ramped = (gap > step_ext) ? PULSE_BITS'(pulse_ff + step_ext) : tgt_cur;
      end else if (pulse_ff > tgt_cur) begin
         gap    = pulse_ff - tgt_cur;
         ramped = (gap > step_ext) ? PULSE_BITS'(pulse_ff - step_ext) : tgt_cur;
      end else begin
         gap    = '0;
         ramped = pulse_ff;
      end
   end

   // sample transactions move the target, ticks move the pulse
   always_comb begin
      if (cmd == CMD_SAMPLE) begin
         pos_in   = decided;
         pulse_in = pulse_ff;
      end else begin
         pos_in   = pos_ff;
         pulse_in = ramped;
      end
      tgt_nxt = target_pulse(pos_in, cfg);
   end

   // axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= CENTER_RESET;
         pos_ff   <= POS_CENTER;
      end else if (step_en) begin
         pulse_ff <= pulse_in;
         pos_ff   <= pos_in;
      end
   end

   assign stat.cur_pulse = pulse_ff;
   assign stat.cur_pos   = pos_ff;
   assign stat.nxt_pulse = pulse_in;
   assign stat.nxt_pos   = pos_in;
   assign stat.at_target = (pulse_in == tgt_nxt);

endmodule

`default_nettype wire

// ===== hw/rtl/sun_tracker_servo_controller.sv =====
// Two-axis light tracker servo controller. Every accepted transaction (sensor
// sample or ramp tick) produces exactly one result carrying both pulse widths,
// both axis targets and a moving flag, all taken after the transaction is
// applied. Throughput is one transaction per cycle while the receiver does not
// stall; each transaction passes the input register, then the result register,
// where its result becomes valid. The rate is set by the axis state update,
// which is combinational between the input register and
// the result register. At most two transactions are in flight; once both
// registers hold one, req_stall follows rsp_stall in the same cycle.
// Configuration writes are always accepted (csr_ready is tied high) and
// should only be issued while no transaction is in flight.
// depends on sttr_pkg, sttr_axis and sun_tracker_servo_controller_macros.svh
`default_nettype none
`include "sun_tracker_servo_controller_macros.svh"

module sun_tracker_servo_controller
   import sttr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_cmd,
   input  wire logic [SAMPLE_BITS-1:0]  req_left_sample,
   input  wire logic [SAMPLE_BITS-1:0]  req_right_sample,
   input  wire logic [SAMPLE_BITS-1:0]  req_upper_sample,
   input  wire logic [SAMPLE_BITS-1:0]  req_lower_sample,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [PULSE_BITS-1:0]        rsp_horiz_pulse_out,
   output logic [PULSE_BITS-1:0]        rsp_vert_pulse_out,
   output logic [1:0]                   rsp_horiz_position,
   output logic [1:0]                   rsp_vert_position,
   output logic                         rsp_moving,
   // configuration write channel
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [PULSE_BITS-1:0]   csr_wdata
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff, in_valid_in;
   logic                  in_cmd_ff;
   logic [SAMPLE_BITS-1:0] in_left_ff, in_right_ff, in_upper_ff, in_lower_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [PULSE_BITS-1:0] out_hpulse_ff, out_vpulse_ff;
   logic [1:0]            out_hpos_ff, out_vpos_ff;
   logic                  out_moving_ff;
   logic                  req_take, advance;
   axis_stat_type         h_stat, v_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THR_RESET;
         cfg_ff.pulse_low    <= LOW_RESET;
         cfg_ff.pulse_center <= CENTER_RESET;
         cfg_ff.pulse_high   <= HIGH_RESET;
         cfg_ff.ramp_step    <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD:  cfg_ff.threshold    <= csr_wdata[THR_BITS-1:0];
            CSR_PULSE_LOW:  cfg_ff.pulse_low    <= csr_wdata;
            CSR_PULSE_CTR:  cfg_ff.pulse_center <= csr_wdata;
            CSR_PULSE_HIGH: cfg_ff.pulse_high   <= csr_wdata;
            CSR_RAMP_STEP:  cfg_ff.ramp_step    <= csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the held transaction moves on when the result slot is empty or its result is being taken
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_cmd_ff   <= req_cmd;
         in_left_ff  <= req_left_sample;
         in_right_ff <= req_right_sample;
         in_upper_ff <= req_upper_sample;
         in_lower_ff <= req_lower_sample;
      end
   end

   // horizontal axis: left is the low end, right the high end
   sttr_axis u_horiz (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .cmd       (in_cmd_ff),
      .low_side  (in_left_ff),
      .high_side (in_right_ff),
      .cfg       (cfg_ff),
      .stat      (h_stat)
   );

   // vertical axis: lower is the low end, upper the high end
   sttr_axis u_vert (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .cmd       (in_cmd_ff),
      .low_side  (in_lower_ff),
      .high_side (in_upper_ff),
      .cfg       (cfg_ff),
      .stat      (v_stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_hpulse_ff <= h_stat.nxt_pulse;
         out_vpulse_ff <= v_stat.nxt_pulse;
         out_hpos_ff   <= h_stat.nxt_pos;
         out_vpos_ff   <= v_stat.nxt_pos;
         out_moving_ff <= !(h_stat.at_target && v_stat.at_target);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_horiz_pulse_out = out_hpulse_ff;
   assign rsp_vert_pulse_out  = out_vpulse_ff;
   assign rsp_horiz_position  = out_hpos_ff;
   assign rsp_vert_position   = out_vpos_ff;
   assign rsp_moving          = out_moving_ff;

   // a sample transaction never moves the pulses
   `STTR_ASSERT_NEXT(a_sample_holds_pulse, advance && in_cmd_ff == CMD_SAMPLE, rsp_horiz_pulse_out == $past(h_stat.cur_pulse) && rsp_vert_pulse_out == $past(v_stat.cur_pulse), "sample transaction moved a pulse")
   // a tick never changes the targets
   `STTR_ASSERT_NEXT(a_tick_holds_pos, advance && in_cmd_ff == CMD_TICK, rsp_horiz_position == $past(h_stat.cur_pos) && rsp_vert_position == $past(v_stat.cur_pos), "tick changed a target")
   // back-pressure only while a transaction is held and the result slot is busy
   `STTR_ASSERT_NOW(a_stall_cause, req_stall, in_valid_ff && out_valid_ff && rsp_stall, "input stalled without a full pipeline")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for the two-axis light tracker servo controller
// drives sample and tick transactions, predicts every result and scoreboards it
// depends on sttr_pkg and the sun_tracker_servo_controller rtl
`timescale 1ns / 100ps

module testbench
   import sttr_pkg::*;
();

   localparam int unsigned DEVIATION_SCALE = 2000;
   localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned PULSE_MAX = (1 << PULSE_BITS) - 1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 180;

   // status that one transaction leaves behind
   typedef struct {
      logic [PULSE_BITS-1:0] horiz_pulse;
      logic [PULSE_BITS-1:0] vert_pulse;
      pos_type               horiz_pos;
      pos_type               vert_pos;
      logic                  moving;
   } servo_status_type;

   // predictor of both axes plus the queue of pending servo status
   class servo_scoreboard_type;
      cfg_type               cfg;
      logic [PULSE_BITS-1:0] horiz_pulse;
      logic [PULSE_BITS-1:0] vert_pulse;
      pos_type               horiz_pos;
      pos_type               vert_pos;
      servo_status_type      expected_status_q[$];
      int                    mismatches;

      function new();
         cfg.threshold    = THR_RESET;
         cfg.pulse_low    = LOW_RESET;
         cfg.pulse_center = CENTER_RESET;
         cfg.pulse_high   = HIGH_RESET;
         cfg.ramp_step    = STEP_RESET;
         horiz_pulse = CENTER_RESET;
         vert_pulse  = CENTER_RESET;
         horiz_pos   = POS_CENTER;
         vert_pos    = POS_CENTER;
         mismatches  = 0;
      endfunction

      // register write, unknown indexes are dropped
      function void write_register(logic [CSR_IDX_BITS-1:0] idx, logic [PULSE_BITS-1:0] data);
         unique case (idx)
            CSR_THRESHOLD:  cfg.threshold    = data[THR_BITS-1:0];
            CSR_PULSE_LOW:  cfg.pulse_low    = data;
            CSR_PULSE_CTR:  cfg.pulse_center = data;
            CSR_PULSE_HIGH: cfg.pulse_high   = data;
            CSR_RAMP_STEP:  cfg.ramp_step    = data[STEP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [PULSE_BITS-1:0] goal_pulse(pos_type pos);
         if (pos == POS_LOW) return cfg.pulse_low;
         if (pos == POS_HIGH) return cfg.pulse_high;
         return cfg.pulse_center;
      endfunction

      // deviation test for one axis, ties and dark sensors go to center
      function pos_type pick_target(logic [SAMPLE_BITS-1:0] low_side,
                                    logic [SAMPLE_BITS-1:0] high_side);
         int unsigned lo;
         int unsigned hi;
         int unsigned diff;
         int unsigned sum;
         int unsigned thr;
         lo   = 32'(low_side);
         hi   = 32'(high_side);
         thr  = 32'(cfg.threshold);
         diff = (lo > hi) ? lo - hi : hi - lo;
         sum  = lo + hi;
         if (DEVIATION_SCALE * diff > thr * sum) begin
            if (lo > hi) return POS_LOW;
            if (lo < hi) return POS_HIGH;
         end
         return POS_CENTER;
      endfunction

      // one ramp step toward the goal, landing exactly on it
      function logic [PULSE_BITS-1:0] step_toward(logic [PULSE_BITS-1:0] cur_pulse,
                                                  logic [PULSE_BITS-1:0] goal_val);
         int unsigned cur;
         int unsigned goal;
         int unsigned stp;
         cur  = 32'(cur_pulse);
         goal = 32'(goal_val);
         stp  = 32'(cfg.ramp_step);
         if (cur < goal) return (goal - cur > stp) ? PULSE_BITS'(cur + stp) : goal_val;
         if (cur > goal) return (cur - goal > stp) ? PULSE_BITS'(cur - stp) : goal_val;
         return cur_pulse;
      endfunction

      // accepted input transaction
      function void add_transaction(logic cmd, logic [SAMPLE_BITS-1:0] left,
                                    logic [SAMPLE_BITS-1:0] right,
                                    logic [SAMPLE_BITS-1:0] upper,
                                    logic [SAMPLE_BITS-1:0] lower);
         servo_status_type st;
         if (cmd == CMD_SAMPLE) begin
            horiz_pos = pick_target(left, right);
            vert_pos  = pick_target(lower, upper);
         end else begin
            horiz_pulse = step_toward(horiz_pulse, goal_pulse(horiz_pos));
            vert_pulse  = step_toward(vert_pulse, goal_pulse(vert_pos));
         end
         st.horiz_pulse = horiz_pulse;
         st.vert_pulse  = vert_pulse;
         st.horiz_pos   = horiz_pos;
         st.vert_pos    = vert_pos;
         st.moving      = (horiz_pulse != goal_pulse(horiz_pos)) ||
                          (vert_pulse != goal_pulse(vert_pos));
         expected_status_q.push_back(st);
      endfunction

      // accepted result transaction against the oldest expectation
      function void check_response(logic [PULSE_BITS-1:0] hp, logic [PULSE_BITS-1:0] vp,
                                   logic [1:0] hpos, logic [1:0] vpos, logic mv);
         servo_status_type want;
         if (expected_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: h=%0d v=%0d hpos=%0d vpos=%0d moving=%0d",
                        hp, vp, hpos, vpos, mv);
            return;
         end
         want = expected_status_q.pop_front();
         if (hp !== want.horiz_pulse || vp !== want.vert_pulse || hpos !== want.horiz_pos ||
             vpos !== want.vert_pos || mv !== want.moving) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected h=%0d v=%0d hpos=%0d vpos=%0d moving=%0d, actual h=%0d v=%0d hpos=%0d vpos=%0d moving=%0d",
                        want.horiz_pulse, want.vert_pulse, want.horiz_pos, want.vert_pos,
                        want.moving, hp, vp, hpos, vpos, mv);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_cmd = CMD_SAMPLE;
   logic [SAMPLE_BITS-1:0]  req_left_sample = '0;
   logic [SAMPLE_BITS-1:0]  req_right_sample = '0;
   logic [SAMPLE_BITS-1:0]  req_upper_sample = '0;
   logic [SAMPLE_BITS-1:0]  req_lower_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PULSE_BITS-1:0]   rsp_horiz_pulse_out;
   logic [PULSE_BITS-1:0]   rsp_vert_pulse_out;
   logic [1:0]              rsp_horiz_position;
   logic [1:0]              rsp_vert_position;
   logic                    rsp_moving;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [PULSE_BITS-1:0]   csr_wdata = '0;

   servo_scoreboard_type sb = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cycle_cnt = 0;

   sun_tracker_servo_controller u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_left_sample(req_left_sample),
      .req_right_sample(req_right_sample),
      .req_upper_sample(req_upper_sample),
      .req_lower_sample(req_lower_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_horiz_pulse_out(rsp_horiz_pulse_out),
      .rsp_vert_pulse_out(rsp_vert_pulse_out),
      .rsp_horiz_position(rsp_horiz_position),
      .rsp_vert_position(rsp_vert_position),
      .rsp_moving(rsp_moving),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver stall pattern, switching between modes
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= ((cycle_cnt % 5) < 2);
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_horiz_pulse_out, rsp_vert_pulse_out, rsp_horiz_position,
                           rsp_vert_position, rsp_moving);
   end

   // one input transaction, with a random gap whenever a burst runs out
   task automatic send_paced(input logic cmd, input logic [SAMPLE_BITS-1:0] left,
                             input logic [SAMPLE_BITS-1:0] right,
                             input logic [SAMPLE_BITS-1:0] upper,
                             input logic [SAMPLE_BITS-1:0] lower);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_left_sample  <= left;
      req_right_sample <= right;
      req_upper_sample <= upper;
      req_lower_sample <= lower;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.add_transaction(cmd, left, right, upper, lower);
   endtask

   // register write, valid stays up for back-to-back writes
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [PULSE_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // stop sending and let every pending result drain
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register settings for one phase of random traffic
   task automatic configure_phase(input int phase);
      int unsigned ctr;
      case (phase)
         0: begin
            // tight pulses and the widest step, lots of clamping
            write_csr(CSR_THRESHOLD, 15'd0);
            write_csr(CSR_PULSE_LOW, 15'd1400);
            write_csr(CSR_PULSE_CTR, 15'd1500);
            write_csr(CSR_PULSE_HIGH, 15'd1600);
            write_csr(CSR_RAMP_STEP, 15'd255);
            write_csr(CSR_IDX_BITS'(CSR_RAMP_STEP + 1), 15'h7FFF);
            write_csr(CSR_IDX_BITS'((1 << CSR_IDX_BITS) - 1), 15'd0);
         end
         1: begin
            write_csr(CSR_THRESHOLD, 15'd2000);
            write_csr(CSR_PULSE_LOW, 15'd0);
            write_csr(CSR_PULSE_CTR, 15'd10000);
            write_csr(CSR_PULSE_HIGH, 15'd20000);
         end
         2: begin
            // oversized threshold and step get masked, the step to zero, which freezes ramps
            write_csr(CSR_THRESHOLD, 15'h7FFF);
            write_csr(CSR_PULSE_HIGH, PULSE_BITS'(PULSE_MAX));
            write_csr(CSR_RAMP_STEP, 15'h7F00);
         end
         3: begin
            write_csr(CSR_THRESHOLD, PULSE_BITS'(THR_RESET));
            write_csr(CSR_PULSE_LOW, LOW_RESET);
            write_csr(CSR_PULSE_CTR, CENTER_RESET);
            write_csr(CSR_PULSE_HIGH, HIGH_RESET);
            write_csr(CSR_RAMP_STEP, PULSE_BITS'(STEP_RESET));
         end
         4: begin
            write_csr(CSR_THRESHOLD, 15'd75);
            write_csr(CSR_PULSE_LOW, 15'd1490);
            write_csr(CSR_PULSE_HIGH, 15'd1510);
            write_csr(CSR_RAMP_STEP, 15'd1);
         end
         default: begin
            ctr = $urandom_range(600, 19400);
            write_csr(CSR_THRESHOLD,
                      PULSE_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                              : $urandom_range(0, 400)));
            write_csr(CSR_PULSE_CTR, PULSE_BITS'(ctr));
            write_csr(CSR_PULSE_LOW, PULSE_BITS'(ctr - $urandom_range(0, 600)));
            write_csr(CSR_PULSE_HIGH, PULSE_BITS'(ctr + $urandom_range(0, 600)));
            write_csr(CSR_RAMP_STEP,
                      PULSE_BITS'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255)));
            write_csr(CSR_IDX_BITS'($urandom_range(CSR_RAMP_STEP + 1, (1 << CSR_IDX_BITS) - 1)),
                      PULSE_BITS'($urandom_range(0, PULSE_MAX)));
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // opposing sensor readings {low side, high side}, often near the threshold
   function automatic logic [2*SAMPLE_BITS-1:0] make_sensor_pair(input int unsigned thr);
      int unsigned a;
      int unsigned b;
      int unsigned d;
      case ($urandom_range(0, 9))
         0, 1: begin
            a = $urandom_range(0, SAMPLE_MAX);
            b = $urandom_range(0, SAMPLE_MAX);
         end
         2: begin
            a = $urandom_range(0, SAMPLE_MAX);
            b = a;
         end
         3: begin
            a = 0;
            b = $urandom_range(0, SAMPLE_MAX);
         end
         4: begin
            a = 0;
            b = 0;
         end
         5: begin
            a = SAMPLE_MAX;
            b = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         end
         default: begin
            // difference placed within a couple of counts of the pass boundary
            a = $urandom_range(50, 3000);
            d = (thr < DEVIATION_SCALE) ? (thr * 2 * a) / (DEVIATION_SCALE - thr) : 0;
            d = d + $urandom_range(0, 4);
            d = (d >= 2) ? d - 2 : 0;
            b = (a + d > SAMPLE_MAX) ? SAMPLE_MAX : a + d;
         end
      endcase
      if ($urandom_range(0, 1))
         return {a[SAMPLE_BITS-1:0], b[SAMPLE_BITS-1:0]};
      else
         return {b[SAMPLE_BITS-1:0], a[SAMPLE_BITS-1:0]};
   endfunction

   // stimulus
   initial begin
      logic [2*SAMPLE_BITS-1:0] hpair;
      logic [2*SAMPLE_BITS-1:0] vpair;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed transactions at reset settings
      send_paced(CMD_SAMPLE, 12'd2000, 12'd2000, 12'd2000, 12'd2000);
      send_paced(CMD_SAMPLE, 12'd0, 12'd0, 12'd0, 12'd0);
      send_paced(CMD_SAMPLE, SAMPLE_FULL, 12'd0, 12'd0, SAMPLE_FULL);
      repeat (3) send_paced(CMD_TICK, SAMPLE_FULL, SAMPLE_FULL, 12'd0, 12'd0);
      send_paced(CMD_SAMPLE, SAMPLE_FULL, 12'd0, 12'd0, SAMPLE_FULL);
      send_paced(CMD_SAMPLE, 12'd0, SAMPLE_FULL, SAMPLE_FULL, 12'd0);
      repeat (2) send_paced(CMD_TICK, 12'd0, 12'd0, SAMPLE_FULL, SAMPLE_FULL);
      // exactly on the threshold fails, one count over passes
      send_paced(CMD_SAMPLE, 12'd2151, 12'd1849, 12'd1849, 12'd2151);
      send_paced(CMD_SAMPLE, 12'd2152, 12'd1849, 12'd1849, 12'd2152);
      repeat (2) send_paced(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0);
      send_paced(CMD_SAMPLE, 12'd1849, 12'd2152, 12'd2152, 12'd1849);
      send_paced(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0);
      send_paced(CMD_SAMPLE, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);
      repeat (2) send_paced(CMD_TICK, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);

      // random traffic, mostly ticks so the ramps reach their targets
      for (int p = 0; p < PHASE_COUNT; p++) begin
         quiesce();
         configure_phase(p);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               send_paced(CMD_TICK, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                          SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                          SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                          SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
            end else begin
               hpair = make_sensor_pair(32'(sb.cfg.threshold));
               vpair = make_sensor_pair(32'(sb.cfg.threshold));
               send_paced(CMD_SAMPLE, hpair[2*SAMPLE_BITS-1:SAMPLE_BITS], hpair[SAMPLE_BITS-1:0],
                          vpair[SAMPLE_BITS-1:0], vpair[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            end
         end
      end

      quiesce();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_status_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
